/* src/plsr_pkg.sv */
// ----------------------------------------------------------------------------
// plsr_pkg: shared types and constants for the port LED status renderer
// Sizes, configuration layout, queue entry and per-port state record.
// ----------------------------------------------------------------------------
package plsr_pkg;

	localparam int PORT_SLOTS  = 64;
	localparam int CHAIN_COUNT = 2;
	localparam int PIDX_W      = $clog2(PORT_SLOTS);
	// images emitted per poll: at most two chains are rendered
	localparam int NUM_IMG     = (CHAIN_COUNT < 2) ? CHAIN_COUNT : 2;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PANEL_ENABLE      = 3'd0,
		CFG_UNKNOWN_GRACE     = 3'd1,
		CFG_SAMPLE_PERIOD     = 3'd2,
		CFG_BLINK_HALF_PERIOD = 3'd3,
		CFG_ACTIVITY_HOLD     = 3'd4
	} cfg_idx_e;

	typedef struct packed {
		logic       panel_enable;
		logic [3:0] unknown_grace;
		logic [7:0] sample_period;
		logic [7:0] blink_half_period;
		logic [3:0] activity_hold;
	} cfg_t;

	typedef enum logic [1:0] {
		COL_DARK  = 2'd0,
		COL_GREEN = 2'd1,
		COL_AMBER = 2'd2
	} colour_t;

	// classified item as it travels from the front to the back
	typedef struct packed {
		logic [PIDX_W-1:0] port_addr;
		logic              port_ok;
		logic              chain;
		logic              chain_ok;
		logic [5:0]        amber_pos;
		logic              known;
		colour_t           link_colour;
		logic              readable;
		logic [63:0]       total;
		logic              eop;
	} item_t;

	typedef struct packed {
		colour_t     colour;
		logic [3:0]  run;
		logic        flag;
		logic [3:0]  hold;
		logic [63:0] base;
	} port_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* src/plsr_front.sv */
// ----------------------------------------------------------------------------
// plsr_front: item intake and classification
// Range-checks port and chain, resolves the link colour, drops items while
// the panel is disabled.
// ----------------------------------------------------------------------------
module plsr_front (
	input  logic             item_valid,
	input  logic [5:0]       port_index,
	input  logic             chain_select,
	input  logic [5:0]       amber_index,
	input  logic             link_known,
	input  logic             link_up,
	input  logic             forwarding,
	input  logic             counters_readable,
	input  logic [63:0]      packet_total,
	input  logic             end_of_poll,
	input  plsr_pkg::cfg_t   cfg,
	output logic             push_valid,
	output plsr_pkg::item_t  push_item
);
	import plsr_pkg::*;

	always_comb begin
		push_item.port_addr = PIDX_W'(port_index);
		push_item.port_ok   = 32'(port_index) < 32'(PORT_SLOTS);
		push_item.chain     = chain_select;
		push_item.chain_ok  = 32'(chain_select) < 32'(CHAIN_COUNT);
		push_item.amber_pos = amber_index;
		push_item.known     = link_known;
		if (!link_up)
			push_item.link_colour = COL_DARK;
		else if (forwarding)
			push_item.link_colour = COL_GREEN;
		else
			push_item.link_colour = COL_AMBER;
		push_item.readable  = counters_readable;
		push_item.total     = packet_total;
		push_item.eop       = end_of_poll;
	end

	assign push_valid = item_valid && cfg.panel_enable;

endmodule

/* src/plsr_queue.sv */
// ----------------------------------------------------------------------------
// plsr_queue: short decoupling queue between front and back
// Flop-based FIFO; full drives the input stall.
// ----------------------------------------------------------------------------
module plsr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  plsr_pkg::item_t  push_item,
	input  logic             pop,
	output plsr_pkg::item_t  head,
	output plsr_pkg::q_stat_t stat
);
	import plsr_pkg::*;

	item_t               ent_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign stat.full  = cnt_q == QCNT_W'(QDEPTH);
	assign stat.empty = cnt_q == '0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* src/plsr_back.sv */
// ----------------------------------------------------------------------------
// plsr_back: per-port state update, lamp images and image output
// Reads the port record on pop, updates it in the execute stage, writes it
// back on commit and accumulates lamp bits; end of poll hands the images
// to the output buffer and advances the sample and blink phases.
// ----------------------------------------------------------------------------
module plsr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  plsr_pkg::cfg_t    cfg,
	input  plsr_pkg::item_t   head,
	input  plsr_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              image_valid,
	input  logic              image_stall,
	output logic              chain_id,
	output logic [63:0]       chain_image,
	output logic              image_last
);
	import plsr_pkg::*;

	port_state_t         st_mem [PORT_SLOTS];
	logic                ent_vld_q [PORT_SLOTS];

	logic                ex_vld_s1;
	item_t               ex_s1;
	port_state_t         rd_st_s1;
	logic                rd_vld_s1;
	logic                byp_hit_s1;
	port_state_t         byp_st_s1;

	logic [63:0]         lamp_q [2];
	logic [63:0]         img_q [2];
	logic [1:0]          out_left_q;
	logic                out_idx_q;
	logic [7:0]          sample_phase_q;
	logic [7:0]          blink_phase_q;
	logic                blank_phase_q;

	port_state_t         old_st;
	port_state_t         new_st;
	colour_t             colour;
	logic                lit;
	logic                moved;
	logic                lamp_on;
	logic [6:0]          bit_pos;
	logic [63:0]         lamp_mask;
	logic [63:0]         lamp_next [2];
	logic                commit;
	logic                wr_en;
	logic [8:0]          sample_nxt;
	logic [8:0]          blink_nxt;

	// end of poll waits for the output buffer to drain
	assign commit = ex_vld_s1 && (!ex_s1.eop || out_left_q == '0);
	assign pop    = !q_stat.empty && (!ex_vld_s1 || commit);
	assign wr_en  = commit && ex_s1.port_ok;

	assign old_st = byp_hit_s1 ? byp_st_s1 : (rd_vld_s1 ? rd_st_s1 : '0);

	always_comb begin
		new_st = old_st;
		moved  = 1'b0;
		if (!ex_s1.known) begin
			if (old_st.run < cfg.unknown_grace) begin
				new_st.run = old_st.run + 1'b1;
				colour     = old_st.colour;
			end else begin
				colour = COL_DARK;
			end
		end else begin
			new_st.run = '0;
			colour     = ex_s1.link_colour;
		end
		new_st.colour = colour;
		lit = (colour == COL_GREEN) || (colour == COL_AMBER);
		if (!lit) begin
			new_st.flag = 1'b0;
			new_st.hold = '0;
			new_st.base = '0;
		end else if (sample_phase_q == '0 && ex_s1.readable) begin
			moved       = (old_st.base != '0) && (ex_s1.total != old_st.base);
			new_st.base = ex_s1.total;
			if (moved)
				new_st.hold = cfg.activity_hold;
			else if (old_st.hold != '0)
				new_st.hold = old_st.hold - 1'b1;
			new_st.flag = new_st.hold != '0;
		end
	end

	always_comb begin
		lamp_on = ex_s1.port_ok && lit && ex_s1.chain_ok && !(new_st.flag && blank_phase_q);
		bit_pos = {1'b0, ex_s1.amber_pos} + ((colour == COL_GREEN) ? 7'd1 : 7'd0);
		// amber at the last chain bit has no green lamp
		lamp_mask = (lamp_on && !bit_pos[6]) ? (64'd1 << bit_pos[5:0]) : '0;
		lamp_next[0] = lamp_q[0] | ((ex_s1.chain == 1'b0) ? lamp_mask : '0);
		lamp_next[1] = lamp_q[1] | ((ex_s1.chain == 1'b1) ? lamp_mask : '0);
	end

	assign sample_nxt = {1'b0, sample_phase_q} + 9'd1;
	assign blink_nxt  = {1'b0, blink_phase_q} + 9'd1;

	// state record memory: write on commit, registered read on pop
	always_ff @(posedge clk) begin
		if (wr_en)
			st_mem[ex_s1.port_addr] <= new_st;
		if (pop)
			rd_st_s1 <= st_mem[head.port_addr];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ex_s1     <= head;
			byp_st_s1 <= new_st;
		end
		if (commit && ex_s1.eop) begin
			img_q[0] <= lamp_next[0];
			img_q[1] <= lamp_next[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORT_SLOTS; i++)
				ent_vld_q[i] <= 1'b0;
			ex_vld_s1      <= 1'b0;
			rd_vld_s1      <= 1'b0;
			byp_hit_s1     <= 1'b0;
			lamp_q[0]      <= '0;
			lamp_q[1]      <= '0;
			out_left_q     <= '0;
			out_idx_q      <= 1'b0;
			sample_phase_q <= '0;
			blink_phase_q  <= '0;
			blank_phase_q  <= 1'b0;
		end else begin
			if (wr_en)
				ent_vld_q[ex_s1.port_addr] <= 1'b1;
			if (pop) begin
				ex_vld_s1  <= 1'b1;
				rd_vld_s1  <= ent_vld_q[head.port_addr];
				// record written this edge is not yet visible in the read data
				byp_hit_s1 <= wr_en && (ex_s1.port_addr == head.port_addr);
			end else if (commit) begin
				ex_vld_s1 <= 1'b0;
			end
			if (image_valid && !image_stall) begin
				out_left_q <= out_left_q - 1'b1;
				out_idx_q  <= out_idx_q + 1'b1;
			end
			if (commit) begin
				if (ex_s1.eop) begin
					lamp_q[0]      <= '0;
					lamp_q[1]      <= '0;
					out_left_q     <= 2'(NUM_IMG);
					out_idx_q      <= 1'b0;
					sample_phase_q <= (sample_nxt >= {1'b0, cfg.sample_period}) ?
						'0 : sample_nxt[7:0];
					if (blink_nxt >= {1'b0, cfg.blink_half_period}) begin
						blink_phase_q <= '0;
						blank_phase_q <= !blank_phase_q;
					end else begin
						blink_phase_q <= blink_nxt[7:0];
					end
				end else begin
					lamp_q[0] <= lamp_next[0];
					lamp_q[1] <= lamp_next[1];
				end
			end
		end
	end

	assign image_valid = out_left_q != '0;
	assign chain_id    = out_idx_q;
	assign chain_image = img_q[out_idx_q];
	assign image_last  = out_idx_q == 1'(NUM_IMG - 1);

endmodule

/* src/port_led_status_renderer.sv */
// ----------------------------------------------------------------------------
// port_led_status_renderer: front-panel port LED renderer
// Per-port colour, failed-query grace, activity blink and chain images.
//
//   channel   handshake                 payload
//   item      item_valid / item_stall   port_index .. end_of_poll
//   image     image_valid / image_stall chain_id, chain_image, image_last
//   cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One port item per cycle while no end-of-poll item waits: the back commits
// one queued item each cycle, with its state record read from a one-read
// one-write memory and bypassed on a repeat.
// Images of a poll leave one per cycle while image_stall is low, after the
// end-of-poll item commits; it waits while older images are still queued.
// Reset clears per-entry valid bits; no clearing pass is needed.
// item_stall rises only when the two-entry queue is full.
// ----------------------------------------------------------------------------
module port_led_status_renderer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [5:0]  port_index,
	input  logic        chain_select,
	input  logic [5:0]  amber_index,
	input  logic        link_known,
	input  logic        link_up,
	input  logic        forwarding,
	input  logic        counters_readable,
	input  logic [63:0] packet_total,
	input  logic        end_of_poll,
	output logic        image_valid,
	input  logic        image_stall,
	output logic        chain_id,
	output logic [63:0] chain_image,
	output logic        image_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [plsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plsr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import plsr_pkg::*;

	cfg_t    cfg_q;
	logic    push_valid;
	item_t   push_item;
	item_t   head;
	q_stat_t q_stat;
	logic    pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_enable      <= 1'b0;
			cfg_q.unknown_grace     <= 4'd3;
			cfg_q.sample_period     <= 8'd10;
			cfg_q.blink_half_period <= 8'd2;
			cfg_q.activity_hold     <= 4'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_e'(cfg_index))
				CFG_PANEL_ENABLE:      cfg_q.panel_enable      <= cfg_data[0];
				CFG_UNKNOWN_GRACE:     cfg_q.unknown_grace     <= cfg_data[3:0];
				CFG_SAMPLE_PERIOD:     cfg_q.sample_period     <= cfg_data;
				CFG_BLINK_HALF_PERIOD: cfg_q.blink_half_period <= cfg_data;
				CFG_ACTIVITY_HOLD:     cfg_q.activity_hold     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	plsr_front u_front (
		.item_valid        (item_valid),
		.port_index        (port_index),
		.chain_select      (chain_select),
		.amber_index       (amber_index),
		.link_known        (link_known),
		.link_up           (link_up),
		.forwarding        (forwarding),
		.counters_readable (counters_readable),
		.packet_total      (packet_total),
		.end_of_poll       (end_of_poll),
		.cfg               (cfg_q),
		.push_valid        (push_valid),
		.push_item         (push_item)
	);

	plsr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	assign item_stall = q_stat.full;

	plsr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.image_valid (image_valid),
		.image_stall (image_stall),
		.chain_id    (chain_id),
		.chain_image (chain_image),
		.image_last  (image_last)
	);

	a_last_chain: assert property (@(posedge clk) disable iff (!arst_n)
		image_valid && image_last |-> chain_id == 1'(NUM_IMG - 1))
		else $error("last image not on the final chain");

	a_poll_images_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		image_valid && !image_stall && !image_last |=> image_valid)
		else $error("images of one poll not back to back");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && cfg_q.panel_enable |=> !q_stat.empty)
		else $error("accepted transaction missing from queue");

endmodule
